// File: hw/rtl/mmcsb_pkg.sv
`default_nettype none

package mmcsb_pkg;

	// Fixed geometry of the card protocol
	localparam int BLOCK_BYTES = 512;
	localparam int WAKE_BYTES  = 10;
	localparam int BC_W        = 10;
	localparam int POLL_W      = 20;
	localparam int RETRY_W     = 8;
	localparam int RESP_LIM_W  = 16;
	localparam int BUSY_LIM_W  = 20;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 20;
	localparam int SECTOR_W    = 23;

	// Result queue depth (holds the two results of one item plus slack)
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	// Register reset values
	localparam logic [RESP_LIM_W-1:0] RESP_POLL_RESET = 16'd4000;
	localparam logic [RETRY_W-1:0]    INIT_RETRY_RESET = 8'd255;
	localparam logic [BUSY_LIM_W-1:0] BUSY_POLL_RESET = 20'd100000;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RESP_POLL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_RETRY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BUSY_POLL  = 2'd2;

	// Operation codes
	localparam logic [2:0] OP_INIT  = 3'd0;
	localparam logic [2:0] OP_READ  = 3'd1;
	localparam logic [2:0] OP_WRITE = 3'd2;
	localparam logic [2:0] OP_WDATA = 3'd3;
	localparam logic [2:0] OP_RECV  = 3'd4;

	// Result kinds
	localparam logic [1:0] KIND_XFER = 2'd0;
	localparam logic [1:0] KIND_RDAT = 2'd1;
	localparam logic [1:0] KIND_NEED = 2'd2;
	localparam logic [1:0] KIND_DONE = 2'd3;

	// Completion status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_RESP   = 3'd1;
	localparam logic [2:0] ST_NO_TOKEN  = 3'd2;
	localparam logic [2:0] ST_REJECTED  = 3'd3;
	localparam logic [2:0] ST_NOT_READY = 3'd4;

	// Card bytes
	localparam logic [7:0] BYTE_IDLE  = 8'hFF;
	localparam logic [7:0] BYTE_TOKEN = 8'hFE;
	localparam logic [7:0] R1_IDLE    = 8'h01;
	localparam logic [7:0] R1_READY   = 8'h00;
	localparam logic [7:0] CMD0_CRC   = 8'h95;
	localparam logic [7:0] CMD0_OP    = 8'h40;
	localparam logic [7:0] CMD1_OP    = 8'h41;
	localparam logic [7:0] CMD16_OP   = 8'h50;
	localparam logic [7:0] CMD17_OP   = 8'h51;
	localparam logic [7:0] CMD24_OP   = 8'h58;
	localparam logic [3:0] RESP_ACCEPTED = 4'h5;
	localparam logic [2:0] CMD_LEN    = 3'd6;

	typedef enum logic [4:0] {
		PH_IDLE, PH_WAKE, PH_CMD0_SEND, PH_CMD0_POLL, PH_CMD1_SEND, PH_CMD1_POLL,
		PH_INIT_GAP, PH_CMD16_SEND, PH_CMD16_POLL, PH_RD_SEND, PH_RD_POLL,
		PH_RD_TOKEN, PH_RD_DATA, PH_RD_CRC, PH_WR_SEND, PH_WR_POLL, PH_WR_TOKEN,
		PH_WR_NEED, PH_WR_DATA, PH_WR_CRC, PH_WR_RESP, PH_WR_BUSY, PH_FINISH
	} phase_t;

	typedef struct packed {
		logic [2:0]          operation;
		logic [SECTOR_W-1:0] sector;
		logic [7:0]          data_byte;
	} in_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] tx_byte;
		logic       card_selected;
		logic [7:0] read_byte;
		logic       last_byte;
		logic [2:0] status;
	} res_t;

	// Results produced by one item, in order
	typedef struct packed {
		logic v0;
		res_t r0;
		logic v1;
		res_t r1;
	} push_t;

	typedef struct packed {
		logic [RESP_LIM_W-1:0] resp_poll_limit;
		logic [RETRY_W-1:0]    init_retry_limit;
		logic [BUSY_LIM_W-1:0] busy_poll_limit;
	} cfg_t;

	function automatic res_t mk_res(logic [1:0] kind, logic [7:0] tx, logic cs,
		logic [7:0] rd, logic last, logic [2:0] st);
		res_t r;
		r.kind          = kind;
		r.tx_byte       = tx;
		r.card_selected = cs;
		r.read_byte     = rd;
		r.last_byte     = last;
		r.status        = st;
		return r;
	endfunction

	function automatic res_t mk_xfer(logic [7:0] tx, logic cs);
		return mk_res(KIND_XFER, tx, cs, 8'h00, 1'b0, ST_OK);
	endfunction

	// Byte idx of the six-byte command frame sent in a send phase
	function automatic logic [7:0] cmd_byte(phase_t ph, logic [2:0] idx,
		logic [SECTOR_W-1:0] sec);
		logic [7:0] op;
		logic       addr;
		logic [7:0] b;
		addr = 1'b0;
		unique case (ph)
			PH_CMD0_SEND:  op = CMD0_OP;
			PH_CMD1_SEND:  op = CMD1_OP;
			PH_CMD16_SEND: op = CMD16_OP;
			PH_RD_SEND: begin
				op   = CMD17_OP;
				addr = 1'b1;
			end
			default: begin
				op   = CMD24_OP;
				addr = 1'b1;
			end
		endcase
		// byte address is sector * 512: bits 31..9 carry the sector
		case (idx)
			3'd0: b = op;
			3'd1: b = addr ? sec[22:15] : 8'h00;
			3'd2: b = addr ? sec[14:7] : 8'h00;
			3'd3: b = addr ? {sec[6:0], 1'b0} : ((ph == PH_CMD16_SEND) ? 8'h02 : 8'h00);
			3'd4: b = 8'h00;
			default: b = (ph == PH_CMD0_SEND) ? CMD0_CRC : BYTE_IDLE;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mmc_spi_block_sequencer.sv
`default_nettype none

// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   in_item (operation, sector, data_byte)
// out       output     out_valid / out_stall out_item (kind .. status)
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item enters per cycle unless stalled; its results are written to the
// result queue from the input register once the queue has room. The queue
// has four slots and the input stalls while fewer than two are free, so items
// with one result keep a rate of one per cycle while out_stall is low; a read
// data byte makes two results and drains at the output's pace. Reset returns
// the sequencer to idle and the limits to defaults. cfg_ready is always high.

module mmc_spi_block_sequencer
	import mmcsb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_t                   in_item,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output res_t                       out_item,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t  cfg;
	push_t push;
	logic  oq_room;

	mmcsb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mmcsb_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.cfg      (cfg),
		.oq_room  (oq_room),
		.push     (push)
	);

	mmcsb_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (oq_room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

// File: hw/rtl/mmcsb_cfg.sv
`default_nettype none

module mmcsb_cfg
	import mmcsb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register file write decode; unknown index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.resp_poll_limit  <= RESP_POLL_RESET;
			cfg_q.init_retry_limit <= INIT_RETRY_RESET;
			cfg_q.busy_poll_limit  <= BUSY_POLL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RESP_POLL:  cfg_q.resp_poll_limit  <= cfg_data[RESP_LIM_W-1:0];
				REG_INIT_RETRY: cfg_q.init_retry_limit <= cfg_data[RETRY_W-1:0];
				REG_BUSY_POLL:  cfg_q.busy_poll_limit  <= cfg_data[BUSY_LIM_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/mmcsb_core.sv
`default_nettype none

module mmcsb_core
	import mmcsb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire in_t  in_item,
	input  wire cfg_t cfg,
	input  wire logic oq_room,
	output push_t     push
);

	logic                item_v_s1;
	in_t                 item_s1;
	logic                fire;

	phase_t              phase_q, phase_n;
	logic [BC_W-1:0]     bc_q, bc_n, bc_inc;
	logic [POLL_W-1:0]   poll_q, poll_n, poll_inc;
	logic [RETRY_W-1:0]  retry_q, retry_n, retry_inc;
	logic [2:0]          idx_q, idx_n, idx_inc;
	logic [SECTOR_W-1:0] sector_q, sector_n;
	logic [2:0]          pend_q, pend_n;

	logic                resp_exh, busy_exh, retry_exh;
	logic                fin;
	logic [2:0]          fin_st;
	logic                st_cmd;
	phase_t              st_ph;
	logic [7:0]          b;

	// Input register: one item waits here until the result queue has room
	assign fire     = item_v_s1 && oq_room;
	assign in_stall = item_v_s1 && !oq_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			item_v_s1 <= 1'b1;
		end else if (fire) begin
			item_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	// Counter increments and limit checks (zero limit acts as one)
	assign b         = item_s1.data_byte;
	assign bc_inc    = bc_q + BC_W'(1);
	assign poll_inc  = poll_q + POLL_W'(1);
	assign retry_inc = retry_q + RETRY_W'(1);
	assign idx_inc   = idx_q + 3'd1;
	assign resp_exh  = (poll_inc >= POLL_W'(cfg.resp_poll_limit))
		|| (cfg.resp_poll_limit == '0);
	assign busy_exh  = (poll_inc >= cfg.busy_poll_limit) || (cfg.busy_poll_limit == '0);
	assign retry_exh = (retry_inc >= cfg.init_retry_limit) || (cfg.init_retry_limit == '0);

	// Sequencer next state, plus the ending and command start decisions
	always_comb begin
		phase_n  = phase_q;
		bc_n     = bc_q;
		poll_n   = poll_q;
		retry_n  = retry_q;
		idx_n    = idx_q;
		sector_n = sector_q;
		pend_n   = pend_q;
		fin      = 1'b0;
		fin_st   = ST_OK;
		st_cmd   = 1'b0;
		st_ph    = PH_CMD1_SEND;

		if (fire) begin
			case (item_s1.operation)
				OP_INIT: begin
					if (phase_q == PH_IDLE) begin
						phase_n = PH_WAKE;
						bc_n    = '0;
					end
				end
				OP_READ, OP_WRITE: begin
					if (phase_q == PH_IDLE) begin
						sector_n = item_s1.sector;
						st_cmd   = 1'b1;
						st_ph    = (item_s1.operation == OP_READ) ? PH_RD_SEND : PH_WR_SEND;
					end
				end
				OP_WDATA: begin
					if (phase_q == PH_WR_NEED) begin
						phase_n = PH_WR_DATA;
					end
				end
				OP_RECV: begin
					unique case (phase_q)
						PH_WAKE: begin
							bc_n = bc_inc;
							if (bc_inc >= BC_W'(WAKE_BYTES)) begin
								st_cmd = 1'b1;
								st_ph  = PH_CMD0_SEND;
							end
						end
						PH_CMD0_SEND, PH_CMD1_SEND, PH_CMD16_SEND, PH_RD_SEND,
						PH_WR_SEND: begin
							idx_n = idx_inc;
							if (idx_inc >= CMD_LEN) begin
								unique case (phase_q)
									PH_CMD0_SEND:  phase_n = PH_CMD0_POLL;
									PH_CMD1_SEND:  phase_n = PH_CMD1_POLL;
									PH_CMD16_SEND: phase_n = PH_CMD16_POLL;
									PH_RD_SEND:    phase_n = PH_RD_POLL;
									default:       phase_n = PH_WR_POLL;
								endcase
								poll_n = '0;
							end
						end
						PH_CMD0_POLL: begin
							if (b == R1_IDLE) begin
								retry_n = '0;
								st_cmd  = 1'b1;
								st_ph   = PH_CMD1_SEND;
							end else begin
								poll_n = poll_inc;
								if (resp_exh) begin
									fin    = 1'b1;
									fin_st = ST_NO_RESP;
								end
							end
						end
						PH_CMD1_POLL: begin
							if (b == R1_READY) begin
								phase_n = PH_INIT_GAP;
							end else begin
								poll_n = poll_inc;
								if (resp_exh) begin
									retry_n = retry_inc;
									if (retry_exh) begin
										fin    = 1'b1;
										fin_st = ST_NOT_READY;
									end else begin
										st_cmd = 1'b1;
										st_ph  = PH_CMD1_SEND;
									end
								end
							end
						end
						PH_INIT_GAP: begin
							st_cmd = 1'b1;
							st_ph  = PH_CMD16_SEND;
						end
						PH_CMD16_POLL, PH_RD_POLL, PH_WR_POLL: begin
							if (b == R1_READY) begin
								if (phase_q == PH_CMD16_POLL) begin
									fin    = 1'b1;
									fin_st = ST_OK;
								end else if (phase_q == PH_RD_POLL) begin
									phase_n = PH_RD_TOKEN;
									poll_n  = '0;
								end else begin
									phase_n = PH_WR_TOKEN;
								end
							end else begin
								poll_n = poll_inc;
								if (resp_exh) begin
									fin    = 1'b1;
									fin_st = ST_NO_RESP;
								end
							end
						end
						PH_RD_TOKEN: begin
							if (b == BYTE_TOKEN) begin
								phase_n = PH_RD_DATA;
								bc_n    = '0;
							end else begin
								poll_n = poll_inc;
								if (resp_exh) begin
									fin    = 1'b1;
									fin_st = ST_NO_TOKEN;
								end
							end
						end
						PH_RD_DATA: begin
							bc_n = bc_inc;
							if (bc_inc >= BC_W'(BLOCK_BYTES)) begin
								phase_n = PH_RD_CRC;
								bc_n    = '0;
							end
						end
						PH_RD_CRC: begin
							bc_n = bc_inc;
							if (bc_inc >= BC_W'(2)) begin
								fin    = 1'b1;
								fin_st = ST_OK;
							end
						end
						PH_WR_TOKEN: begin
							phase_n = PH_WR_NEED;
							bc_n    = '0;
						end
						PH_WR_DATA: begin
							bc_n = bc_inc;
							if (bc_inc >= BC_W'(BLOCK_BYTES)) begin
								phase_n = PH_WR_CRC;
								bc_n    = '0;
							end else begin
								phase_n = PH_WR_NEED;
							end
						end
						PH_WR_CRC: begin
							bc_n = bc_inc;
							if (bc_inc >= BC_W'(2)) begin
								phase_n = PH_WR_RESP;
							end
						end
						PH_WR_RESP: begin
							if (b[3:0] != RESP_ACCEPTED) begin
								fin    = 1'b1;
								fin_st = ST_REJECTED;
							end else begin
								phase_n = PH_WR_BUSY;
								poll_n  = '0;
							end
						end
						PH_WR_BUSY: begin
							// busy timeout also ends with ok
							if (b != R1_READY) begin
								fin    = 1'b1;
								fin_st = ST_OK;
							end else begin
								poll_n = poll_inc;
								if (busy_exh) begin
									fin    = 1'b1;
									fin_st = ST_OK;
								end
							end
						end
						PH_FINISH: begin
							phase_n = PH_IDLE;
						end
						default: ;
					endcase
				end
				default: ;
			endcase

			// Ending: wait for the dummy byte, then report
			if (fin) begin
				pend_n  = fin_st;
				phase_n = PH_FINISH;
			end

			// Command start: frame index restarts
			if (st_cmd) begin
				phase_n = st_ph;
				idx_n   = '0;
			end
		end
	end

	// Results of the item in the input register
	always_comb begin
		push = '0;
		if (fire) begin
			if (fin) begin
				// deselect and clock one dummy byte
				push.v0 = 1'b1;
				push.r0 = mk_xfer(BYTE_IDLE, 1'b0);
			end else if (st_cmd) begin
				// first frame byte goes out selected
				push.v0 = 1'b1;
				push.r0 = mk_xfer(cmd_byte(st_ph, 3'd0, sector_n), 1'b1);
			end else begin
				case (item_s1.operation)
					OP_INIT: begin
						if (phase_q == PH_IDLE) begin
							push.v0 = 1'b1;
							push.r0 = mk_xfer(BYTE_IDLE, 1'b0);
						end
					end
					OP_WDATA: begin
						if (phase_q == PH_WR_NEED) begin
							push.v0 = 1'b1;
							push.r0 = mk_xfer(b, 1'b1);
						end
					end
					OP_RECV: begin
						unique case (phase_q)
							PH_IDLE, PH_WR_NEED: ;
							PH_WAKE: begin
								push.v0 = 1'b1;
								push.r0 = mk_xfer(BYTE_IDLE, 1'b0);
							end
							PH_CMD0_SEND, PH_CMD1_SEND, PH_CMD16_SEND, PH_RD_SEND,
							PH_WR_SEND: begin
								push.v0 = 1'b1;
								if (idx_inc >= CMD_LEN) begin
									push.r0 = mk_xfer(BYTE_IDLE, 1'b1);
								end else begin
									push.r0 = mk_xfer(cmd_byte(phase_q, idx_inc, sector_q), 1'b1);
								end
							end
							PH_CMD1_POLL: begin
								// ready card is deselected for the gap byte
								push.v0 = 1'b1;
								push.r0 = mk_xfer(BYTE_IDLE, b != R1_READY);
							end
							PH_WR_POLL: begin
								push.v0 = 1'b1;
								push.r0 = mk_xfer((b == R1_READY) ? BYTE_TOKEN : BYTE_IDLE, 1'b1);
							end
							PH_RD_DATA: begin
								// data byte out, then the next byte clocked
								push.v0 = 1'b1;
								push.r0 = mk_res(KIND_RDAT, 8'h00, 1'b0, b,
									bc_q == BC_W'(BLOCK_BYTES - 1), ST_OK);
								push.v1 = 1'b1;
								push.r1 = mk_xfer(BYTE_IDLE, 1'b1);
							end
							PH_WR_TOKEN: begin
								push.v0 = 1'b1;
								push.r0 = mk_res(KIND_NEED, 8'h00, 1'b0, 8'h00,
									BLOCK_BYTES == 1, ST_OK);
							end
							PH_WR_DATA: begin
								push.v0 = 1'b1;
								if (bc_inc >= BC_W'(BLOCK_BYTES)) begin
									push.r0 = mk_xfer(BYTE_IDLE, 1'b1);
								end else begin
									push.r0 = mk_res(KIND_NEED, 8'h00, 1'b0, 8'h00,
										bc_inc == BC_W'(BLOCK_BYTES - 1), ST_OK);
								end
							end
							PH_FINISH: begin
								push.v0 = 1'b1;
								push.r0 = mk_res(KIND_DONE, 8'h00, 1'b0, 8'h00, 1'b0, pend_q);
							end
							// remaining polls and CRC bytes clock one more byte
							default: begin
								push.v0 = 1'b1;
								push.r0 = mk_xfer(BYTE_IDLE, 1'b1);
							end
						endcase
					end
					default: ;
				endcase
			end
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			bc_q     <= '0;
			poll_q   <= '0;
			retry_q  <= '0;
			idx_q    <= '0;
			sector_q <= '0;
			pend_q   <= '0;
		end else begin
			phase_q  <= phase_n;
			bc_q     <= bc_n;
			poll_q   <= poll_n;
			retry_q  <= retry_n;
			idx_q    <= idx_n;
			sector_q <= sector_n;
			pend_q   <= pend_n;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/mmcsb_outq.sv
`default_nettype none

module mmcsb_outq
	import mmcsb_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       room,
	output logic       out_valid,
	input  wire logic  out_stall,
	output res_t       out_item
);

	res_t                mem_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wr_q, rd_q;
	logic [OQ_CNT_W-1:0] cnt_q;
	logic                pop;
	logic [OQ_CNT_W-1:0] n_push;

	// Room for the two results one item can make
	assign room      = cnt_q <= OQ_CNT_W'(OQ_DEPTH - 2);
	assign out_valid = cnt_q != '0;
	assign out_item  = mem_q[rd_q];
	assign pop       = out_valid && !out_stall;
	assign n_push    = OQ_CNT_W'(push.v0) + OQ_CNT_W'(push.v1);

	// Storage: up to two writes per cycle at consecutive slots
	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.v1) begin
			mem_q[wr_q + OQ_PTR_W'(1)] <= push.r1;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + OQ_PTR_W'(n_push);
			rd_q  <= rd_q + OQ_PTR_W'(pop);
			cnt_q <= cnt_q + n_push - OQ_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire
